/* hw/rtl/ptbs_pkg.sv */
`default_nettype none

package ptbs_pkg;

   localparam int OP_W     = 3;
   localparam int THREAD_W = 2;
   localparam int SIZE_W   = 9;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W  = 9;

   localparam int START_ADDRESS  = 0;
   localparam int MAX_ITEM_BYTES = 8;

   localparam int BANKS  = 8;
   localparam int BANK_W = $clog2(BANKS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
   localparam logic [OP_W-1:0] OP_REWIND = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SIZE  = 2'd2;

   typedef enum logic [2:0] {
      KIND_PUSH,
      KIND_POP,
      KIND_LOAD,
      KIND_REWIND,
      KIND_QUERY,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [THREAD_W-1:0]   thread;
      logic                  thread_bad;
      logic                  size_err;
      logic [SIZE_W-1:0]     size;
      logic [DATA_W-1:0]     push_data;
   } cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/ptbs_front.sv */
`default_nettype none

module ptbs_front #(
   parameter int THREADS = 4
) (
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [ptbs_pkg::OP_W-1:0]      req_op,
   input  wire logic [ptbs_pkg::THREAD_W-1:0]  req_thread,
   input  wire logic [ptbs_pkg::SIZE_W-1:0]    req_size,
   input  wire logic [ptbs_pkg::DATA_W-1:0]    req_push_data,
   input  wire logic                           q_full,
   output logic                                q_push,
   output ptbs_pkg::cmd_type                   q_cmd
);

   ptbs_pkg::kind_type kind;

   always_comb begin
      case (req_op)
         ptbs_pkg::OP_PUSH:   kind = ptbs_pkg::KIND_PUSH;
         ptbs_pkg::OP_POP:    kind = ptbs_pkg::KIND_POP;
         ptbs_pkg::OP_LOAD:   kind = ptbs_pkg::KIND_LOAD;
         ptbs_pkg::OP_REWIND: kind = ptbs_pkg::KIND_REWIND;
         ptbs_pkg::OP_QUERY:  kind = ptbs_pkg::KIND_QUERY;
         default:             kind = ptbs_pkg::KIND_NOP;
      endcase
   end

   always_comb begin
      q_cmd.kind       = kind;
      q_cmd.thread     = req_thread;
      q_cmd.thread_bad = !(32'(req_thread) < THREADS);
      q_cmd.size_err   = ((kind == ptbs_pkg::KIND_PUSH) || (kind == ptbs_pkg::KIND_LOAD))
                         && (req_size > ptbs_pkg::SIZE_W'(ptbs_pkg::MAX_ITEM_BYTES));
      q_cmd.size       = req_size;
      q_cmd.push_data  = req_push_data;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

/* hw/rtl/ptbs_queue.sv */
`default_nettype none

module ptbs_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_push,
   input  wire ptbs_pkg::cmd_type  q_cmd_in,
   output logic                    q_full,
   input  wire logic               q_pop,
   output ptbs_pkg::cmd_type       q_cmd_out,
   output logic                    q_empty
);

   localparam int PW = ptbs_pkg::QUEUE_PTR_W;
   localparam int CW = ptbs_pkg::QUEUE_PTR_W + 1;

   ptbs_pkg::cmd_type entry_ff [ptbs_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign q_full    = (count_ff == CW'(ptbs_pkg::QUEUE_DEPTH));
   assign q_empty   = (count_ff == '0);
   assign q_cmd_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(ptbs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(ptbs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_cmd_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ptbs_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("request written into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("request taken from an empty queue");

endmodule

`default_nettype wire

/* hw/rtl/ptbs_back.sv */
`default_nettype none

module ptbs_back #(
   parameter int THREADS     = 4,
   parameter int STACK_BYTES = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_empty,
   input  wire ptbs_pkg::cmd_type              q_cmd,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [ptbs_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ptbs_pkg::DATA_W-1:0]         rsp_load_data,
   output logic                                rsp_frame_exists,
   output logic [ptbs_pkg::LEVEL_W-1:0]        rsp_top_level
);

   localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int PW    = $clog2(STACK_BYTES + 1);
   localparam int CW    = ((PW > ptbs_pkg::SIZE_W) ? PW : ptbs_pkg::SIZE_W) + 1;
   localparam int ROWS  = STACK_BYTES / ptbs_pkg::BANKS + 2;
   localparam int RW    = $clog2(ROWS);
   localparam int AW    = TW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int BW    = ptbs_pkg::BANK_W;
   localparam int LW    = ptbs_pkg::BANK_W + 1;

   typedef enum logic [1:0] {
      BK_EXEC   = 2'b01,
      BK_FINISH = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [PW-1:0] top_ff [THREADS];
   logic [PW-1:0] top_in [THREADS];
   logic [PW-1:0] rp_ff  [THREADS];
   logic [PW-1:0] rp_in  [THREADS];

   logic [TW-1:0] th;
   logic [PW-1:0] top_cur, rp_cur, base;
   logic [CW-1:0] top_w, rp_w, size_w, level_w;
   logic          push_ok, pop_ok, load_ok, rewind;
   logic          exec;
   logic [BW-1:0] off;
   logic [RW-1:0] row_base;

   logic [ptbs_pkg::STATUS_W-1:0] status_in, status_ff;
   logic                          exists_in, exists_ff;
   logic [ptbs_pkg::LEVEL_W-1:0]  level_ff;
   logic                          load_ok_ff;
   logic [BW-1:0]                 off_ff;
   logic [LW-1:0]                 size_ff;

   logic [7:0] bank_q_ff [ptbs_pkg::BANKS];

   logic                          out_free, load_out;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ptbs_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ptbs_pkg::DATA_W-1:0]   rsp_load_data_ff, rsp_load_data_in;
   logic                          rsp_frame_exists_ff;
   logic [ptbs_pkg::LEVEL_W-1:0]  rsp_top_level_ff;

   assign exec  = (state_ff == BK_EXEC) && !q_empty;
   assign q_pop = exec;
   assign th    = TW'(q_cmd.thread);

   // Checks and the new pointer values for the request at the head of the queue.
   always_comb begin
      top_cur   = top_ff[th];
      rp_cur    = rp_ff[th];
      top_w     = CW'(top_cur);
      rp_w      = CW'(rp_cur);
      size_w    = CW'(q_cmd.size);
      level_w   = top_w;
      status_in = ptbs_pkg::STATUS_OK;
      exists_in = 1'b0;
      push_ok   = 1'b0;
      pop_ok    = 1'b0;
      load_ok   = 1'b0;
      rewind    = 1'b0;
      case (q_cmd.kind)
         ptbs_pkg::KIND_PUSH: begin
            if (q_cmd.size_err) begin
               status_in = ptbs_pkg::STATUS_SIZE;
            end else if (top_w + size_w > CW'(STACK_BYTES)) begin
               status_in = ptbs_pkg::STATUS_RANGE;
            end else begin
               push_ok = 1'b1;
               level_w = top_w + size_w;
            end
         end
         ptbs_pkg::KIND_POP: begin
            if (size_w > top_w - CW'(ptbs_pkg::START_ADDRESS)) begin
               status_in = ptbs_pkg::STATUS_RANGE;
            end else begin
               pop_ok  = 1'b1;
               level_w = top_w - size_w;
            end
         end
         ptbs_pkg::KIND_LOAD: begin
            if (q_cmd.size_err) begin
               status_in = ptbs_pkg::STATUS_SIZE;
            end else if (rp_w + size_w > top_w) begin
               status_in = ptbs_pkg::STATUS_RANGE;
            end else begin
               load_ok = 1'b1;
            end
         end
         ptbs_pkg::KIND_REWIND: begin
            rewind = 1'b1;
         end
         ptbs_pkg::KIND_QUERY: begin
            exists_in = (rp_w + size_w <= top_w);
         end
         default: begin
         end
      endcase
      if (q_cmd.thread_bad) begin
         status_in = ptbs_pkg::STATUS_RANGE;
         exists_in = 1'b0;
         push_ok   = 1'b0;
         pop_ok    = 1'b0;
         load_ok   = 1'b0;
         rewind    = 1'b0;
         level_w   = '0;
      end
   end

   always_comb begin
      for (int t = 0; t < THREADS; t++) begin
         top_in[t] = top_ff[t];
         rp_in[t]  = rp_ff[t];
      end
      if (exec && (push_ok || pop_ok)) begin
         top_in[th] = PW'(level_w);
      end
      if (exec && load_ok) begin
         rp_in[th] = PW'(rp_w + size_w);
      end
      if (exec && rewind) begin
         rp_in[th] = PW'(ptbs_pkg::START_ADDRESS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < THREADS; t++) begin
            top_ff[t] <= PW'(ptbs_pkg::START_ADDRESS);
            rp_ff[t]  <= PW'(ptbs_pkg::START_ADDRESS);
         end
      end else begin
         for (int t = 0; t < THREADS; t++) begin
            top_ff[t] <= top_in[t];
            rp_ff[t]  <= rp_in[t];
         end
      end
   end

   // A push writes above the top and a load reads above the read pointer, so the
   // first byte of either sits at the pointer's offset from the start address.
   assign base     = push_ok ? top_cur - PW'(ptbs_pkg::START_ADDRESS)
                             : rp_cur - PW'(ptbs_pkg::START_ADDRESS);
   assign off      = base[BW-1:0];
   assign row_base = RW'(base[PW-1:BW]);

   for (genvar b = 0; b < ptbs_pkg::BANKS; b++) begin : g_bank
      logic [7:0]    bank_mem [DEPTH];
      logic [BW-1:0] lane;
      logic [RW-1:0] row;
      logic [AW-1:0] addr;
      logic          wr_en;
      logic          rd_en;

      // Bytes that wrap past the last bank of a row go into the next row.
      always_comb begin
         lane  = BW'(b) - off;
         row   = row_base + RW'(BW'(b) < off);
         addr  = {th, row};
         wr_en = exec && push_ok && (ptbs_pkg::SIZE_W'(lane) < q_cmd.size);
         rd_en = exec && (q_cmd.kind == ptbs_pkg::KIND_LOAD);
      end

      always_ff @(posedge clock) begin
         if (wr_en) begin
            bank_mem[addr] <= q_cmd.push_data[{lane, 3'b000} +: 8];
         end
         if (rd_en) begin
            bank_q_ff[b] <= bank_mem[addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff  <= status_in;
         exists_ff  <= exists_in;
         level_ff   <= ptbs_pkg::LEVEL_W'(level_w);
         load_ok_ff <= load_ok;
         off_ff     <= off;
         size_ff    <= q_cmd.size[LW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_EXEC: begin
            if (!q_empty) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_EXEC;
            end
         end
         default: state_in = BK_EXEC;
      endcase
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load_out     = (state_ff == BK_FINISH) && out_free;
   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_comb begin
      logic [BW-1:0] src;
      for (int i = 0; i < ptbs_pkg::BANKS; i++) begin
         src = off_ff + BW'(i);
         rsp_load_data_in[8*i +: 8] = (load_ok_ff && (LW'(i) < size_ff)) ? bank_q_ff[src]
                                                                           : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_EXEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status_ff       <= status_ff;
         rsp_load_data_ff    <= rsp_load_data_in;
         rsp_frame_exists_ff <= exists_ff;
         rsp_top_level_ff    <= level_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_load_data    = rsp_load_data_ff;
   assign rsp_frame_exists = rsp_frame_exists_ff;
   assign rsp_top_level    = rsp_top_level_ff;

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ptbs_pkg::STATUS_OK)) |-> (rsp_load_data == '0))
      else $error("failed request returned load data");

   a_exists_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_exists) |-> (rsp_status == ptbs_pkg::STATUS_OK))
      else $error("frame reported on a failed request");

   a_pop_finish: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == BK_FINISH))
      else $error("request taken without completion step");

endmodule

`default_nettype wire

/* hw/rtl/per_thread_byte_stack_unit.sv */
`default_nettype none

// Channel  Dir  Handshake              Fields
// req      in   req_valid, req_stall   req_op, req_thread, req_size, req_push_data
// rsp      out  rsp_valid, rsp_stall   rsp_status, rsp_load_data, rsp_frame_exists,
//                                      rsp_top_level
//
// Each request passes the execution states BK_EXEC and BK_FINISH in turn: the first
// checks and updates the thread's pointers and accesses the eight byte banks, and
// the second gathers bank data into the response register before the next one starts.
// A two-entry queue takes requests while the previous one executes.
// Synchronous reset returns every top and read pointer to the start address; stack
// contents are not cleared. Execution waits while a response is held by rsp_stall.

module per_thread_byte_stack_unit #(
   parameter int THREADS     = 4,
   parameter int STACK_BYTES = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [ptbs_pkg::OP_W-1:0]      req_op,
   input  wire logic [ptbs_pkg::THREAD_W-1:0]  req_thread,
   input  wire logic [ptbs_pkg::SIZE_W-1:0]    req_size,
   input  wire logic [ptbs_pkg::DATA_W-1:0]    req_push_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [ptbs_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ptbs_pkg::DATA_W-1:0]         rsp_load_data,
   output logic                                rsp_frame_exists,
   output logic [ptbs_pkg::LEVEL_W-1:0]        rsp_top_level
);

   logic              q_full, q_empty, q_push, q_pop;
   ptbs_pkg::cmd_type front_cmd, head_cmd;

   ptbs_front #(
      .THREADS(THREADS)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_thread    (req_thread),
      .req_size      (req_size),
      .req_push_data (req_push_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (front_cmd)
   );

   ptbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .q_cmd_in  (front_cmd),
      .q_full    (q_full),
      .q_pop     (q_pop),
      .q_cmd_out (head_cmd),
      .q_empty   (q_empty)
   );

   ptbs_back #(
      .THREADS     (THREADS),
      .STACK_BYTES (STACK_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_load_data    (rsp_load_data),
      .rsp_frame_exists (rsp_frame_exists),
      .rsp_top_level    (rsp_top_level)
   );

endmodule

`default_nettype wire

/* tb/per_thread_byte_stack_unit_tb.sv */
`timescale 1ns / 1ps

module per_thread_byte_stack_unit_tb;

   localparam int THREADS       = 4;
   localparam int STACK_BYTES   = 256;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int GEN_VIEW      = 0;
   localparam int DUT_VIEW      = 1;

   typedef struct packed {
      logic [ptbs_pkg::OP_W-1:0]     op;
      logic [ptbs_pkg::THREAD_W-1:0] thread;
      logic [ptbs_pkg::SIZE_W-1:0]   size;
      logic [ptbs_pkg::DATA_W-1:0]   push_data;
   } stack_req_type;

   typedef struct packed {
      logic [ptbs_pkg::STATUS_W-1:0] status;
      logic [ptbs_pkg::DATA_W-1:0]   load_data;
      logic                          frame_exists;
      logic [ptbs_pkg::LEVEL_W-1:0]  top_level;
   } stack_rsp_type;

   logic                          clock;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [ptbs_pkg::OP_W-1:0]     req_op        = '0;
   logic [ptbs_pkg::THREAD_W-1:0] req_thread    = '0;
   logic [ptbs_pkg::SIZE_W-1:0]   req_size      = '0;
   logic [ptbs_pkg::DATA_W-1:0]   req_push_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [ptbs_pkg::STATUS_W-1:0] rsp_status;
   logic [ptbs_pkg::DATA_W-1:0]   rsp_load_data;
   logic                          rsp_frame_exists;
   logic [ptbs_pkg::LEVEL_W-1:0]  rsp_top_level;

   // Two copies of the stack state: one steers the stimulus as it is built,
   // the other follows the requests the block actually accepts.
   logic [7:0] stack_mem [2][THREADS][STACK_BYTES+1];
   int         top_ptr   [2][THREADS];
   int         read_ptr  [2][THREADS];

   stack_req_type pending_requests[$];
   stack_rsp_type expected_responses[$];
   stack_req_type held_req;
   stack_rsp_type want;
   int            errors     = 0;
   int            burst_left = 0;
   int            gap_left   = 0;
   int            stall_left = 0;
   int            idle_count = 0;

   per_thread_byte_stack_unit #(
      .THREADS     (THREADS),
      .STACK_BYTES (STACK_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_thread       (req_thread),
      .req_size         (req_size),
      .req_push_data    (req_push_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_load_data    (rsp_load_data),
      .rsp_frame_exists (rsp_frame_exists),
      .rsp_top_level    (rsp_top_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic stack_rsp_type apply_stack_op(input int v, input stack_req_type r);
      stack_rsp_type e;
      int            t;
      int            top;
      int            rdp;
      int            sz;
      e   = '0;
      t   = r.thread;
      top = top_ptr[v][t];
      rdp = read_ptr[v][t];
      sz  = r.size;
      case (r.op)
         ptbs_pkg::OP_PUSH: begin
            if (sz > ptbs_pkg::MAX_ITEM_BYTES) begin
               e.status = ptbs_pkg::STATUS_SIZE;
            end else if (top + sz > STACK_BYTES) begin
               e.status = ptbs_pkg::STATUS_RANGE;
            end else begin
               for (int i = 0; i < sz; i++)
                  stack_mem[v][t][top + 1 + i - ptbs_pkg::START_ADDRESS] =
                     r.push_data[8*i +: 8];
               top_ptr[v][t] = top + sz;
            end
         end
         ptbs_pkg::OP_POP: begin
            if (sz > top - ptbs_pkg::START_ADDRESS) e.status = ptbs_pkg::STATUS_RANGE;
            else top_ptr[v][t] = top - sz;
         end
         ptbs_pkg::OP_LOAD: begin
            if (sz > ptbs_pkg::MAX_ITEM_BYTES) begin
               e.status = ptbs_pkg::STATUS_SIZE;
            end else if (rdp + sz > top) begin
               e.status = ptbs_pkg::STATUS_RANGE;
            end else begin
               for (int i = 0; i < sz; i++)
                  e.load_data[8*i +: 8] =
                     stack_mem[v][t][rdp + 1 + i - ptbs_pkg::START_ADDRESS];
               read_ptr[v][t] = rdp + sz;
            end
         end
         ptbs_pkg::OP_REWIND: read_ptr[v][t] = ptbs_pkg::START_ADDRESS;
         ptbs_pkg::OP_QUERY:  e.frame_exists = (rdp + sz <= top);
         default: ;
      endcase
      e.top_level = ptbs_pkg::LEVEL_W'(top_ptr[v][t]);
      return e;
   endfunction

   function automatic logic [ptbs_pkg::DATA_W-1:0] random_bytes();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_request(input logic [ptbs_pkg::OP_W-1:0] op, input int th,
                                         input int size,
                                         input logic [ptbs_pkg::DATA_W-1:0] data);
      stack_req_type r;
      r.op        = op;
      r.thread    = ptbs_pkg::THREAD_W'(th);
      r.size      = ptbs_pkg::SIZE_W'(size);
      r.push_data = data;
      void'(apply_stack_op(GEN_VIEW, r));
      pending_requests.push_back(r);
   endfunction

   initial begin
      int th;
      int pick;
      int n;
      int avail;
      int limit;
      for (int v = 0; v < 2; v++) begin
         for (int t = 0; t < THREADS; t++) begin
            top_ptr[v][t]  = ptbs_pkg::START_ADDRESS;
            read_ptr[v][t] = ptbs_pkg::START_ADDRESS;
            for (int a = 0; a <= STACK_BYTES; a++) stack_mem[v][t][a] = 8'h00;
         end
      end

      // Directed opening: empty stack, size limits, reads past the top and a
      // read pointer left above the top by pops.
      queue_request(ptbs_pkg::OP_QUERY, 0, 0, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 0, '0);
      queue_request(ptbs_pkg::OP_POP, 0, 0, '0);
      queue_request(ptbs_pkg::OP_POP, 0, 1, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 1, '0);
      queue_request(ptbs_pkg::OP_PUSH, 0, 8, '1);
      queue_request(ptbs_pkg::OP_PUSH, 0, 8, '0);
      queue_request(ptbs_pkg::OP_PUSH, 0, 9, '1);
      queue_request(ptbs_pkg::OP_PUSH, 1, 256, '1);
      queue_request(ptbs_pkg::OP_LOAD, 0, 9, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 8, '0);
      queue_request(ptbs_pkg::OP_QUERY, 0, 8, '0);
      queue_request(ptbs_pkg::OP_QUERY, 0, 9, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 8, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 1, '0);
      queue_request(ptbs_pkg::OP_REWIND, 0, 256, '1);
      queue_request(ptbs_pkg::OP_POP, 0, 12, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 5, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 4, '0);
      queue_request(ptbs_pkg::OP_POP, 0, 4, '0);
      queue_request(ptbs_pkg::OP_QUERY, 0, 0, '0);
      queue_request(ptbs_pkg::OP_LOAD, 0, 0, '0);
      queue_request(ptbs_pkg::OP_PUSH, 3, 7, random_bytes());
      queue_request(ptbs_pkg::OP_PUSH, 2, 1, random_bytes());
      queue_request(3'd5, 3, 3, '1);
      queue_request(3'd6, 2, 0, '0);
      queue_request(3'd7, 1, 256, '1);

      limit = pending_requests.size() + RANDOM_ITEMS;
      while (pending_requests.size() < limit) begin
         th   = $urandom_range(0, THREADS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            // Fill one stack to the brim, then push and pop at the limits.
            while (top_ptr[GEN_VIEW][th] + 8 <= STACK_BYTES)
               queue_request(ptbs_pkg::OP_PUSH, th, 8, random_bytes());
            queue_request(ptbs_pkg::OP_PUSH, th, STACK_BYTES - top_ptr[GEN_VIEW][th],
                          random_bytes());
            queue_request(ptbs_pkg::OP_PUSH, th, $urandom_range(1, 8), random_bytes());
            queue_request(ptbs_pkg::OP_QUERY, th, $urandom_range(0, 256), random_bytes());
            if ($urandom_range(0, 1) == 1)
               queue_request(ptbs_pkg::OP_POP, th, STACK_BYTES, '0);
            else
               queue_request(ptbs_pkg::OP_POP, th, $urandom_range(0, 256), random_bytes());
         end else if (pick < 55) begin
            n = $urandom_range(1, 6);
            repeat (n)
               queue_request(ptbs_pkg::OP_PUSH, th, $urandom_range(0, 8), random_bytes());
            if ($urandom_range(0, 3) == 0)
               queue_request(ptbs_pkg::OP_REWIND, th, $urandom_range(0, 256),
                             random_bytes());
            n = $urandom_range(1, 6);
            repeat (n) begin
               avail = top_ptr[GEN_VIEW][th] - read_ptr[GEN_VIEW][th];
               if (avail < 0) avail = 0;
               if (avail > ptbs_pkg::MAX_ITEM_BYTES) avail = ptbs_pkg::MAX_ITEM_BYTES;
               if ($urandom_range(0, 4) == 0)
                  queue_request(ptbs_pkg::OP_QUERY, th, $urandom_range(0, 9),
                                random_bytes());
               else
                  queue_request(ptbs_pkg::OP_LOAD, th, $urandom_range(0, avail),
                                random_bytes());
            end
         end else if (pick < 70) begin
            avail = top_ptr[GEN_VIEW][th];
            if (avail > 40) avail = 40;
            queue_request(ptbs_pkg::OP_POP, th, $urandom_range(0, avail), random_bytes());
            queue_request($urandom_range(0, 1) == 1 ? ptbs_pkg::OP_LOAD : ptbs_pkg::OP_QUERY,
                          th, $urandom_range(0, 8), random_bytes());
         end else begin
            queue_request(ptbs_pkg::OP_W'($urandom_range(0, 7)), th,
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 256)
                                                    : $urandom_range(0, 10),
                          random_bytes());
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Checked away from the active edge so that every update of that edge is seen.
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[per_thread_byte_stack_unit] OK");
      end else begin
         $display("[per_thread_byte_stack_unit] ERROR");
      end
      $finish;
   end

   // Request driver: bursts of back-to-back requests separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_responses.push_back(apply_stack_op(DUT_VIEW, held_req));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || pending_requests.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               held_req      = pending_requests.pop_front();
               req_valid     <= 1'b1;
               req_op        <= held_req.op;
               req_thread    <= held_req.thread;
               req_size      <= held_req.size;
               req_push_data <= held_req.push_data;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                           : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Response stall: alternating runs of ready and stalled cycles, with
   // occasional long stretches free of stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 1) begin
         stall_left--;
      end else if (rsp_stall) begin
         stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 20);
         rsp_stall <= 1'b0;
      end else begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15)
                                                  : $urandom_range(1, 4);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_load_data !== want.load_data) begin
               $error("load_data: expected %h, actual %h", want.load_data, rsp_load_data);
               errors++;
            end
            if (rsp_frame_exists !== want.frame_exists) begin
               $error("frame_exists: expected %0d, actual %0d", want.frame_exists,
                      rsp_frame_exists);
               errors++;
            end
            if (rsp_top_level !== want.top_level) begin
               $error("top_level: expected %0d, actual %0d", want.top_level, rsp_top_level);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a request.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("[per_thread_byte_stack_unit] ERROR");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

endmodule

/* sim.f */
hw/rtl/ptbs_pkg.sv
hw/rtl/ptbs_front.sv
hw/rtl/ptbs_queue.sv
hw/rtl/ptbs_back.sv
hw/rtl/per_thread_byte_stack_unit.sv
tb/per_thread_byte_stack_unit_tb.sv
